/* rtl/ncd_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder package
// Shared constants for the decoder: default code size, generator row
// register reset values and result field widths.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MSG_BITS_DEF  = 3;
    localparam int CODE_BITS_DEF = 6;

    localparam int NUM_ROW_REGS = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam int WEIGHT_BITS = 3;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 3'd7;

    localparam logic [63:0] ROW_RESET [NUM_ROW_REGS] = '{64'd25, 64'd50, 64'd44};

endpackage

/* rtl/ncd_channels.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder channels
// Valid/ready channels for received words, decode results and generator
// row writes.
// ----------------------------------------------------------------------------
interface ncd_word_if #(
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] received_word;

    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

interface ncd_result_if #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) ();
    import ncd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MSG_BITS-1:0]    message;
    logic [CODE_BITS-1:0]   error_pattern;
    logic [WEIGHT_BITS-1:0] error_weight;

    modport source (output valid, output message, output error_pattern,
                    output error_weight, input ready);
    modport sink   (input valid, input message, input error_pattern,
                    input error_weight, output ready);
endinterface

interface ncd_cfg_if #(
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) ();
    import ncd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CODE_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ncd_encoder.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder encoder
// Forms the codeword of one message as the GF(2) sum of the generator rows
// that its bits select.
// ----------------------------------------------------------------------------
module ncd_encoder #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) (
    input  logic [MSG_BITS-1:0][CODE_BITS-1:0] i_rows,
    input  logic [MSG_BITS-1:0]                i_msg,
    output logic [CODE_BITS-1:0]               o_codeword
);

    // Row i is selected by message bit MSG_BITS-1-i.
    always_comb begin
        o_codeword = '0;
        for (int i = 0; i < MSG_BITS; i++) begin
            if (i_msg[MSG_BITS-1-i]) begin
                o_codeword = o_codeword ^ i_rows[i];
            end
        end
    end

endmodule

/* rtl/ncd_gen_regs.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder generator rows
// Holds the writable generator rows; rows without a register read as zero
// and writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ncd_gen_regs #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [ncd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [CODE_BITS-1:0]                 i_cfg_data,
    output logic                                 o_cfg_ready,
    output logic [MSG_BITS-1:0][CODE_BITS-1:0]   o_rows
);
    import ncd_pkg::*;

    assign o_cfg_ready = 1'b1;

    for (genvar g = 0; g < MSG_BITS; g++) begin : g_row
        if (g < NUM_ROW_REGS) begin : g_reg
            logic [CODE_BITS-1:0] r_row;
            logic [CODE_BITS-1:0] n_row;

            always_comb begin
                n_row = r_row;
                if (i_cfg_valid && (i_cfg_index == CFG_IDX_BITS'(g))) begin
                    n_row = i_cfg_data;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_row <= ROW_RESET[g][CODE_BITS-1:0];
                end else begin
                    r_row <= n_row;
                end
            end

            assign o_rows[g] = r_row;
        end else begin : g_zero
            assign o_rows[g] = '0;
        end
    end

endmodule

/* rtl/ncd_weigh.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder weighing stage
// Registers the received word and works out the Hamming distance from it
// to every candidate codeword.
// ----------------------------------------------------------------------------
module ncd_weigh #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF,
    localparam int NCAND    = 1 << MSG_BITS,
    localparam int WT_BITS  = $clog2(CODE_BITS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [CODE_BITS-1:0]               i_rx,
    output logic                               o_ready,
    input  logic [MSG_BITS-1:0][CODE_BITS-1:0] i_rows,
    input  logic                               i_take,
    output logic                               o_valid,
    output logic [CODE_BITS-1:0]               o_rx,
    output logic [NCAND-1:0][WT_BITS-1:0]      o_wt
);
    import ncd_pkg::*;

    logic                            r_a_valid;
    logic [CODE_BITS-1:0]            r_rx_a;
    logic [NCAND-1:0][WT_BITS-1:0]   n_wt;
    logic [NCAND-1:0][CODE_BITS-1:0] cand_cw;
    logic                            en_a;

    assign en_a    = !r_a_valid || i_take;
    assign o_ready = en_a;

    for (genvar m = 0; m < NCAND; m++) begin : g_cand
        ncd_encoder #(
            .MSG_BITS  (MSG_BITS),
            .CODE_BITS (CODE_BITS)
        ) u_enc (
            .i_rows     (i_rows),
            .i_msg      (MSG_BITS'(m)),
            .o_codeword (cand_cw[m])
        );

        assign n_wt[m] = WT_BITS'($countones(r_rx_a ^ cand_cw[m]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_rx_a <= i_rx;
        end
    end

    assign o_valid = r_a_valid;
    assign o_rx    = r_rx_a;
    assign o_wt    = n_wt;

endmodule

/* rtl/ncd_select.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder selection stage
// Picks the lowest message of least distance with a compare tree, rebuilds
// its error pattern and registers the result beat.
// ----------------------------------------------------------------------------
module ncd_select #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF,
    localparam int NCAND    = 1 << MSG_BITS,
    localparam int WT_BITS  = $clog2(CODE_BITS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [CODE_BITS-1:0]                 i_rx,
    input  logic [NCAND-1:0][WT_BITS-1:0]        i_wt,
    input  logic [MSG_BITS-1:0][CODE_BITS-1:0]   i_rows,
    output logic                                 o_take,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [MSG_BITS-1:0]                  o_message,
    output logic [CODE_BITS-1:0]                 o_error_pattern,
    output logic [ncd_pkg::WEIGHT_BITS-1:0]      o_error_weight
);
    import ncd_pkg::*;

    logic [MSG_BITS:0][NCAND-1:0][WT_BITS-1:0]  lvl_wt;
    logic [MSG_BITS:0][NCAND-1:0][MSG_BITS-1:0] lvl_idx;
    logic [MSG_BITS-1:0]        best_msg;
    logic [7:0]                 best_wt;
    logic [CODE_BITS-1:0]       best_cw;
    logic                       r_valid;
    logic [MSG_BITS-1:0]        r_message;
    logic [CODE_BITS-1:0]       r_error;
    logic [WEIGHT_BITS-1:0]     r_weight;
    logic [MSG_BITS-1:0]        n_message;
    logic [CODE_BITS-1:0]       n_error;
    logic [WEIGHT_BITS-1:0]     n_weight;

    // The left entry of each pair has the lower message, so it keeps ties.
    always_comb begin
        lvl_wt  = '0;
        lvl_idx = '0;
        for (int n = 0; n < NCAND; n++) begin
            lvl_wt[0][n]  = i_wt[n];
            lvl_idx[0][n] = MSG_BITS'(n);
        end
        for (int l = 0; l < MSG_BITS; l++) begin
            for (int n = 0; n < (NCAND >> (l + 1)); n++) begin
                if (lvl_wt[l][2*n+1] < lvl_wt[l][2*n]) begin
                    lvl_wt[l+1][n]  = lvl_wt[l][2*n+1];
                    lvl_idx[l+1][n] = lvl_idx[l][2*n+1];
                end else begin
                    lvl_wt[l+1][n]  = lvl_wt[l][2*n];
                    lvl_idx[l+1][n] = lvl_idx[l][2*n];
                end
            end
        end
    end

    assign best_msg = lvl_idx[MSG_BITS][0];
    assign best_wt  = 8'(lvl_wt[MSG_BITS][0]);

    ncd_encoder #(
        .MSG_BITS  (MSG_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_enc (
        .i_rows     (i_rows),
        .i_msg      (best_msg),
        .o_codeword (best_cw)
    );

    assign n_message = best_msg;
    assign n_error   = i_rx ^ best_cw;
    assign n_weight  = (best_wt > 8'(WEIGHT_MAX)) ? WEIGHT_MAX : WEIGHT_BITS'(best_wt);

    assign o_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_message <= n_message;
            r_error   <= n_error;
            r_weight  <= n_weight;
        end
    end

    assign o_valid         = r_valid;
    assign o_message       = r_message;
    assign o_error_pattern = r_error;
    assign o_error_weight  = r_weight;

endmodule

/* rtl/nearest_codeword_decoder.sv */
// ----------------------------------------------------------------------------
// Nearest codeword decoder
// Decodes each received word to the message whose codeword lies nearest.
//
// The word channel takes one received word per beat. The result channel
// returns one beat per word, in order: the message, the error pattern and
// the error weight, saturated at seven. Ties go to the lower message.
// The configuration channel writes generator rows by index; it is always
// ready, and writes to indexes without a row are dropped.
// A word is taken into an input register, then passes through the distance,
// compare and re-encode logic in one pass into a result register. One word
// is accepted every cycle while the receiver is ready; the two registers
// hold up to two words in flight.
// When the receiver stalls, the result register and then the input register
// fill, and ready on the word channel drops once both hold a word.
// Reset empties both registers and loads the default [6,3] generator rows.
// ----------------------------------------------------------------------------
module nearest_codeword_decoder #(
    parameter int MSG_BITS  = ncd_pkg::MSG_BITS_DEF,
    parameter int CODE_BITS = ncd_pkg::CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ncd_word_if.sink      i_word,
    ncd_cfg_if.sink       i_cfg,
    ncd_result_if.source  o_result
);
    import ncd_pkg::*;

    localparam int NCAND   = 1 << MSG_BITS;
    localparam int WT_BITS = $clog2(CODE_BITS + 1);

    logic [MSG_BITS-1:0][CODE_BITS-1:0] rows;
    logic                               wt_valid;
    logic [CODE_BITS-1:0]               wt_rx;
    logic [NCAND-1:0][WT_BITS-1:0]      wt;
    logic                               sel_take;

    ncd_gen_regs #(
        .MSG_BITS  (MSG_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_gen_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .o_rows      (rows)
    );

    ncd_weigh #(
        .MSG_BITS  (MSG_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_weigh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_word.valid),
        .i_rx    (i_word.received_word),
        .o_ready (i_word.ready),
        .i_rows  (rows),
        .i_take  (sel_take),
        .o_valid (wt_valid),
        .o_rx    (wt_rx),
        .o_wt    (wt)
    );

    ncd_select #(
        .MSG_BITS  (MSG_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_select (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (wt_valid),
        .i_rx            (wt_rx),
        .i_wt            (wt),
        .i_rows          (rows),
        .o_take          (sel_take),
        .i_ready         (o_result.ready),
        .o_valid         (o_result.valid),
        .o_message       (o_result.message),
        .o_error_pattern (o_result.error_pattern),
        .o_error_weight  (o_result.error_weight)
    );

endmodule
